// ----- rtl/core/acrms_pkg.sv -----
// ----------------------------------------------------------------------------
// acrms_pkg
// Shared widths, constants, register indexes and types of the AC RMS
// accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package acrms_pkg;

   localparam int SUM_W       = 40;   // square sum
   localparam int COUNT_W     = 17;   // sample count
   localparam int THR_W       = 16;
   localparam int GAIN_W      = 10;
   localparam int OFS_W       = 12;
   localparam int RMS_W       = 12;
   localparam int POW_W       = 24;
   localparam int PROD_W      = 22;   // any product divided by 1000 stays below 2^22
   localparam int MV_W        = 12;   // millivolts, at most 3300
   localparam int MAG_W       = 12;   // |mv - offset|
   localparam int SCL_W       = 13;   // scaled magnitude, at most 4189
   localparam int SQ_W        = 25;
   localparam int RECIP_W     = 23;
   localparam int RECIP_SHIFT = 32;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 16;

   // ceil(2^32 / 1000): floor(x * RECIP >> 32) == x / 1000 for x < 2^22
   localparam logic [RECIP_W-1:0] RECIP_1000 = 23'd4294968;

   localparam logic [CSR_ADDR_W-1:0] CSR_ENABLE            = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_SAMPLE_THRESHOLD  = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_VOLT_GAIN         = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_VOLTAGE_OFFSET_MV = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_CURR_GAIN         = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_CURRENT_OFFSET_MV = 3'd5;

   localparam logic [THR_W-1:0]  RST_SAMPLE_THRESHOLD  = 16'd10000;
   localparam logic [GAIN_W-1:0] RST_VOLT_GAIN         = 10'd121;
   localparam logic [OFS_W-1:0]  RST_VOLTAGE_OFFSET_MV = 12'd1680;
   localparam logic [GAIN_W-1:0] RST_CURR_GAIN         = 10'd149;
   localparam logic [OFS_W-1:0]  RST_CURRENT_OFFSET_MV = 12'd1420;

   typedef struct packed {
      logic [GAIN_W-1:0] gain;
      logic [OFS_W-1:0]  offset;
   } lane_cfg_type;

   typedef struct packed {
      logic start;
      logic clear;
   } lane_ctl_type;

   typedef struct packed {
      logic             valid;
      logic [RMS_W-1:0] volt_rms;
      logic [RMS_W-1:0] curr_rms;
      logic [POW_W-1:0] power_rms;
   } merge_rsp_type;

endpackage

`default_nettype wire

// ----- rtl/core/acrms_lane.sv -----
// ----------------------------------------------------------------------------
// acrms_lane
// One channel: ADC code to millivolts, offset removal, gain scaling and
// saturating square accumulation, as a six stage pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module acrms_lane #(
   parameter int ADC_BITS = 12
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire  acrms_pkg::lane_ctl_type     ctl,
   input  wire  acrms_pkg::lane_cfg_type     cfg,
   input  wire  [ADC_BITS-1:0]               code,
   output logic [acrms_pkg::SUM_W-1:0]       sum,
   output logic                              done
);

   localparam int MV_PER_CODE = 3300000 / ((1 << ADC_BITS) - 1);
   localparam int MUL_W       = acrms_pkg::PROD_W + acrms_pkg::RECIP_W;
   localparam logic [acrms_pkg::PROD_W-1:0] MV_K = acrms_pkg::PROD_W'(MV_PER_CODE);

   logic [5:0]                        vld_ff, vld_in;
   logic [acrms_pkg::PROD_W-1:0]      p1_ff, p1_in;
   logic [acrms_pkg::MV_W-1:0]        mv_ff, mv_in;
   logic [acrms_pkg::PROD_W-1:0]      p3_ff, p3_in;
   logic [acrms_pkg::SCL_W-1:0]       a_ff, a_in;
   logic [acrms_pkg::SQ_W-1:0]        sq_ff, sq_in;
   logic [acrms_pkg::SUM_W-1:0]       sum_ff, sum_in;

   logic [MUL_W-1:0]                  p2_full, p4_full;
   logic [acrms_pkg::MV_W:0]          diff_u, mag_full;
   logic [2*acrms_pkg::SCL_W-1:0]     sq_full;
   logic [acrms_pkg::SUM_W:0]         acc;

   assign vld_in = {vld_ff[4:0], ctl.start};

   // stage 1: code to millivolts times 1000
   assign p1_in = MV_K * acrms_pkg::PROD_W'(code);

   // stage 2: divide by 1000
   assign p2_full = MUL_W'(p1_ff) * MUL_W'(acrms_pkg::RECIP_1000);
   assign mv_in   = p2_full[acrms_pkg::RECIP_SHIFT +: acrms_pkg::MV_W];

   // stage 3: offset removal and gain; only the magnitude matters from here on
   assign diff_u   = {1'b0, mv_ff} - {1'b0, cfg.offset};
   assign mag_full = diff_u[acrms_pkg::MV_W] ? (~diff_u + 1'b1) : diff_u;
   assign p3_in    = acrms_pkg::PROD_W'(cfg.gain)
                   * acrms_pkg::PROD_W'(mag_full[acrms_pkg::MAG_W-1:0]);

   // stage 4: divide by 1000, truncation toward zero on the magnitude
   assign p4_full = MUL_W'(p3_ff) * MUL_W'(acrms_pkg::RECIP_1000);
   assign a_in    = p4_full[acrms_pkg::RECIP_SHIFT +: acrms_pkg::SCL_W];

   // stage 5: square
   assign sq_full = a_ff * a_ff;
   assign sq_in   = sq_full[acrms_pkg::SQ_W-1:0];

   // stage 6: saturating accumulate
   assign acc = {1'b0, sum_ff} + (acrms_pkg::SUM_W + 1)'(sq_ff);

   always_comb begin
      sum_in = sum_ff;
      if (ctl.clear) begin
         sum_in = '0;
      end else if (vld_ff[4]) begin
         sum_in = acc[acrms_pkg::SUM_W] ? '1 : acc[acrms_pkg::SUM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         sum_ff <= '0;
      end else begin
         vld_ff <= vld_in;
         sum_ff <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      p1_ff <= p1_in;
      mv_ff <= mv_in;
      p3_ff <= p3_in;
      a_ff  <= a_in;
      sq_ff <= sq_in;
   end

   assign sum  = sum_ff;
   assign done = vld_ff[5];

endmodule

`default_nettype wire

// ----- rtl/core/acrms_merge.sv -----
// ----------------------------------------------------------------------------
// acrms_merge
// Combines the lane sums: two restoring dividers by the sample count, two
// bit-pair square roots, saturation and the power product.
// ----------------------------------------------------------------------------
`default_nettype none

module acrms_merge (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 start,
   input  wire  [acrms_pkg::SUM_W-1:0]         sum_v,
   input  wire  [acrms_pkg::SUM_W-1:0]         sum_c,
   input  wire  [acrms_pkg::COUNT_W-1:0]       count,
   input  wire                                 take,
   output acrms_pkg::merge_rsp_type            rsp
);

   localparam int SW     = acrms_pkg::SUM_W;
   localparam int CW     = acrms_pkg::COUNT_W;
   localparam int RW     = acrms_pkg::RMS_W;
   localparam int STEP_W = $clog2(SW);
   localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(SW - 1);
   localparam logic [SW-1:0] SQRT_BIT0 = {2'b01, {(SW - 2){1'b0}}};

   localparam logic [2:0] M_IDLE = 3'd0;
   localparam logic [2:0] M_DIV  = 3'd1;
   localparam logic [2:0] M_SQRT = 3'd2;
   localparam logic [2:0] M_SAT  = 3'd3;
   localparam logic [2:0] M_MUL  = 3'd4;
   localparam logic [2:0] M_HOLD = 3'd5;

   logic [2:0]          state_ff, state_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [SW-1:0]       qv_ff, qv_in, qc_ff, qc_in;
   logic [CW-1:0]       remv_ff, remv_in, remc_ff, remc_in;
   logic [CW-1:0]       den_ff, den_in;
   logic [SW-1:0]       resv_ff, resv_in, resc_ff, resc_in;
   logic [SW-1:0]       bit_ff, bit_in;
   logic [RW-1:0]       vr_ff, vr_in, ir_ff, ir_in;
   logic [acrms_pkg::POW_W-1:0] pow_ff, pow_in;

   logic [CW+SW-1:0]    divv, divc;
   logic [2*SW-1:0]     sqv, sqc;

   // one quotient bit: returns {remainder, shifted quotient}
   function automatic logic [CW+SW-1:0] div_step(input logic [CW-1:0] rem,
                                                 input logic [SW-1:0] q,
                                                 input logic [CW-1:0] den);
      logic [CW:0] r;
      logic        qb;
      r  = {rem, q[SW-1]};
      qb = 1'b0;
      if (r >= {1'b0, den}) begin
         r  = r - {1'b0, den};
         qb = 1'b1;
      end
      return {r[CW-1:0], q[SW-2:0], qb};
   endfunction

   // one root bit: returns {remainder, partial root}
   function automatic logic [2*SW-1:0] sqrt_step(input logic [SW-1:0] x,
                                                 input logic [SW-1:0] res,
                                                 input logic [SW-1:0] b);
      logic [SW:0]   t;
      logic [SW-1:0] xn;
      logic [SW-1:0] rn;
      t  = {1'b0, res} + {1'b0, b};
      xn = x;
      rn = res >> 1;
      if ({1'b0, x} >= t) begin
         xn = x - t[SW-1:0];
         rn = (res >> 1) + b;
      end
      return {xn, rn};
   endfunction

   function automatic logic [RW-1:0] sat_rms(input logic [SW-1:0] r);
      return (|r[SW-1:RW]) ? '1 : r[RW-1:0];
   endfunction

   assign divv = div_step(remv_ff, qv_ff, den_ff);
   assign divc = div_step(remc_ff, qc_ff, den_ff);
   // during the root phase the quotient registers hold the running remainder
   assign sqv  = sqrt_step(qv_ff, resv_ff, bit_ff);
   assign sqc  = sqrt_step(qc_ff, resc_ff, bit_ff);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      qv_in    = qv_ff;
      qc_in    = qc_ff;
      remv_in  = remv_ff;
      remc_in  = remc_ff;
      den_in   = den_ff;
      resv_in  = resv_ff;
      resc_in  = resc_ff;
      bit_in   = bit_ff;
      vr_in    = vr_ff;
      ir_in    = ir_ff;
      pow_in   = pow_ff;
      case (state_ff)
         M_IDLE: begin
            if (start) begin
               qv_in    = sum_v;
               qc_in    = sum_c;
               remv_in  = '0;
               remc_in  = '0;
               den_in   = count;
               step_in  = '0;
               state_in = M_DIV;
            end
         end
         M_DIV: begin
            {remv_in, qv_in} = divv;
            {remc_in, qc_in} = divc;
            step_in = step_ff + 1'b1;
            if (step_ff == DIV_LAST) begin
               resv_in  = '0;
               resc_in  = '0;
               bit_in   = SQRT_BIT0;
               state_in = M_SQRT;
            end
         end
         M_SQRT: begin
            {qv_in, resv_in} = sqv;
            {qc_in, resc_in} = sqc;
            bit_in = bit_ff >> 2;
            if (bit_ff[0]) begin
               state_in = M_SAT;
            end
         end
         M_SAT: begin
            vr_in    = sat_rms(resv_ff);
            ir_in    = sat_rms(resc_ff);
            state_in = M_MUL;
         end
         M_MUL: begin
            pow_in   = acrms_pkg::POW_W'(vr_ff) * acrms_pkg::POW_W'(ir_ff);
            state_in = M_HOLD;
         end
         M_HOLD: begin
            if (take) begin
               state_in = M_IDLE;
            end
         end
         default: begin
            state_in = M_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      qv_ff   <= qv_in;
      qc_ff   <= qc_in;
      remv_ff <= remv_in;
      remc_ff <= remc_in;
      den_ff  <= den_in;
      resv_ff <= resv_in;
      resc_ff <= resc_in;
      bit_ff  <= bit_in;
      vr_ff   <= vr_in;
      ir_ff   <= ir_in;
      pow_ff  <= pow_in;
   end

   assign rsp.valid     = (state_ff == M_HOLD);
   assign rsp.volt_rms  = vr_ff;
   assign rsp.curr_rms  = ir_ff;
   assign rsp.power_rms = pow_ff;

endmodule

`default_nettype wire

// ----- rtl/core/ac_rms_accumulator_top.sv -----
// ----------------------------------------------------------------------------
// ac_rms_accumulator_top
// True-RMS by sum of squares: voltage and current lanes accumulate squared,
// scaled samples; past the threshold the merge unit emits both RMS values
// and their product.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  req       in         req_valid/req_stall  req_voltage_code, req_current_code
//  rsp       out        rsp_valid/rsp_stall  rsp_volt_rms, rsp_curr_rms,
//                                            rsp_power_rms
//  csr       in         csr_write_enable     csr_index, csr_data
//
//  An enabled item passes through the lane pipeline; a disabled item is accepted and dropped.
//  Closing a window runs the merge unit: 40 divide steps,
//  20 root steps, saturation, power multiply and the output load.
//  A result waits in the output register while the next item is taken;
//  a second result is held in the merge unit until the first drains.
//  Synchronous active-high reset clears sums, count and control.
// ----------------------------------------------------------------------------
`default_nettype none

module ac_rms_accumulator_top #(
   parameter int ADC_BITS = 12
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire  [ADC_BITS-1:0]                   req_voltage_code,
   input  wire  [ADC_BITS-1:0]                   req_current_code,
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output logic [acrms_pkg::RMS_W-1:0]           rsp_volt_rms,
   output logic [acrms_pkg::RMS_W-1:0]           rsp_curr_rms,
   output logic [acrms_pkg::POW_W-1:0]           rsp_power_rms,
   input  wire                                   csr_write_enable,
   input  wire  [acrms_pkg::CSR_ADDR_W-1:0]      csr_index,
   input  wire  [acrms_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam logic [1:0] T_IDLE  = 2'd0;
   localparam logic [1:0] T_LANE  = 2'd1;
   localparam logic [1:0] T_MERGE = 2'd2;

   localparam int CW = acrms_pkg::COUNT_W;

   logic                             enable_ff;
   logic [acrms_pkg::THR_W-1:0]      thr_ff;
   acrms_pkg::lane_cfg_type          vcfg_ff, ccfg_ff;

   logic [1:0]                       state_ff, state_in;
   logic [CW-1:0]                    count_ff, count_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic [acrms_pkg::RMS_W-1:0]      vr_ff, ir_ff;
   logic [acrms_pkg::POW_W-1:0]      pow_ff;

   acrms_pkg::lane_ctl_type          lane_ctl;
   acrms_pkg::merge_rsp_type         merge_rsp;
   logic [acrms_pkg::SUM_W-1:0]      sum_v, sum_c;
   logic                             done_v, done_c, lane_done;
   logic                             accept, emit, take;
   logic [CW-1:0]                    count_inc;

   assign req_stall = (state_ff != T_IDLE);
   assign accept    = req_valid & ~req_stall;
   assign lane_done = done_v & done_c;

   assign count_inc = count_ff + 1'b1;
   assign emit      = (count_inc > CW'(thr_ff)) & (count_inc != '0);

   assign lane_ctl.start = accept & enable_ff;
   assign lane_ctl.clear = lane_done & emit;

   assign take = merge_rsp.valid & (~rsp_valid_ff | ~rsp_stall);

   acrms_lane #(.ADC_BITS(ADC_BITS)) u_lane_v (
      .clock (clock),
      .reset (reset),
      .ctl   (lane_ctl),
      .cfg   (vcfg_ff),
      .code  (req_voltage_code),
      .sum   (sum_v),
      .done  (done_v)
   );

   acrms_lane #(.ADC_BITS(ADC_BITS)) u_lane_c (
      .clock (clock),
      .reset (reset),
      .ctl   (lane_ctl),
      .cfg   (ccfg_ff),
      .code  (req_current_code),
      .sum   (sum_c),
      .done  (done_c)
   );

   acrms_merge u_merge (
      .clock (clock),
      .reset (reset),
      .start (lane_ctl.clear),
      .sum_v (sum_v),
      .sum_c (sum_c),
      .count (count_inc),
      .take  (take),
      .rsp   (merge_rsp)
   );

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      case (state_ff)
         T_IDLE: begin
            if (lane_ctl.start) begin
               state_in = T_LANE;
            end
         end
         T_LANE: begin
            if (lane_done) begin
               count_in = emit ? '0 : count_inc;
               state_in = emit ? T_MERGE : T_IDLE;
            end
         end
         T_MERGE: begin
            if (take) begin
               state_in = T_IDLE;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = take | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= T_IDLE;
         count_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
         enable_ff      <= 1'b0;
         thr_ff         <= acrms_pkg::RST_SAMPLE_THRESHOLD;
         vcfg_ff.gain   <= acrms_pkg::RST_VOLT_GAIN;
         vcfg_ff.offset <= acrms_pkg::RST_VOLTAGE_OFFSET_MV;
         ccfg_ff.gain   <= acrms_pkg::RST_CURR_GAIN;
         ccfg_ff.offset <= acrms_pkg::RST_CURRENT_OFFSET_MV;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            case (csr_index)
               acrms_pkg::CSR_ENABLE:
                  enable_ff <= csr_data[0];
               acrms_pkg::CSR_SAMPLE_THRESHOLD:
                  thr_ff <= csr_data[acrms_pkg::THR_W-1:0];
               acrms_pkg::CSR_VOLT_GAIN:
                  vcfg_ff.gain <= csr_data[acrms_pkg::GAIN_W-1:0];
               acrms_pkg::CSR_VOLTAGE_OFFSET_MV:
                  vcfg_ff.offset <= csr_data[acrms_pkg::OFS_W-1:0];
               acrms_pkg::CSR_CURR_GAIN:
                  ccfg_ff.gain <= csr_data[acrms_pkg::GAIN_W-1:0];
               acrms_pkg::CSR_CURRENT_OFFSET_MV:
                  ccfg_ff.offset <= csr_data[acrms_pkg::OFS_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         vr_ff  <= merge_rsp.volt_rms;
         ir_ff  <= merge_rsp.curr_rms;
         pow_ff <= merge_rsp.power_rms;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_volt_rms  = vr_ff;
   assign rsp_curr_rms  = ir_ff;
   assign rsp_power_rms = pow_ff;

endmodule

`default_nettype wire

// ----- rtl/core/acrms_checker.sv -----
// ----------------------------------------------------------------------------
// acrms_checker
// Port-level checks of the AC RMS accumulator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module acrms_checker #(
   parameter int ADC_BITS = 12
) (
   input wire                               clock,
   input wire                               reset,
   input wire                               req_valid,
   input wire                               req_stall,
   input wire [ADC_BITS-1:0]                req_voltage_code,
   input wire [ADC_BITS-1:0]                req_current_code,
   input wire                               rsp_valid,
   input wire                               rsp_stall,
   input wire [acrms_pkg::RMS_W-1:0]        rsp_volt_rms,
   input wire [acrms_pkg::RMS_W-1:0]        rsp_curr_rms,
   input wire [acrms_pkg::POW_W-1:0]        rsp_power_rms,
   input wire                               csr_write_enable,
   input wire [acrms_pkg::CSR_ADDR_W-1:0]   csr_index,
   input wire [acrms_pkg::CSR_DATA_W-1:0]   csr_data
);

   logic enable_ff;
   logic accept;
   logic [ADC_BITS-1:0] code_mix;

   assign accept   = req_valid & ~req_stall;
   assign code_mix = req_voltage_code ^ req_current_code;

   // shadow of the enable register
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
      end else if (csr_write_enable && (csr_index == acrms_pkg::CSR_ENABLE)) begin
         enable_ff <= csr_data[0];
      end
   end

   // a disabled item is dropped and the block stays open
   a_disabled_drop: assert property (@(posedge clock) disable iff (reset)
      accept && !enable_ff |=> !req_stall)
      else $error("disabled item did not leave the block idle");

   // an enabled item occupies the lanes
   a_enabled_busy: assert property (@(posedge clock) disable iff (reset)
      accept && enable_ff && (code_mix == code_mix) |=> req_stall)
      else $error("enabled item did not make the block busy");

   // results are only loaded while an item is in work
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared with no item in work");

   a_power_product: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_power_rms ==
         (acrms_pkg::POW_W'(rsp_volt_rms) * acrms_pkg::POW_W'(rsp_curr_rms)))
      else $error("power is not the product of the rms values");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_volt_rms)
         && $stable(rsp_curr_rms) && $stable(rsp_power_rms))
      else $error("stalled result changed");

endmodule

bind ac_rms_accumulator_top acrms_checker #(.ADC_BITS(ADC_BITS)) u_acrms_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_voltage_code (req_voltage_code),
   .req_current_code (req_current_code),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_volt_rms     (rsp_volt_rms),
   .rsp_curr_rms     (rsp_curr_rms),
   .rsp_power_rms    (rsp_power_rms),
   .csr_write_enable (csr_write_enable),
   .csr_index        (csr_index),
   .csr_data         (csr_data)
);

`default_nettype wire
